// ----- hw/rtl/bmns_pkg.sv -----
package bmns_pkg;

    localparam int UW          = 15;
    localparam int UNIFORM_MAX = 32767;
    localparam int DW          = 32;

    typedef logic [4:0] t_op;

    localparam t_op OP_NOP      = 5'd0;
    localparam t_op OP_LOAD     = 5'd1;
    localparam t_op OP_UNI_MUL  = 5'd2;
    localparam t_op OP_UNI_FIN  = 5'd3;
    localparam t_op OP_PEND     = 5'd4;
    localparam t_op OP_SIG_MUL  = 5'd5;
    localparam t_op OP_SIG_FIN  = 5'd6;
    localparam t_op OP_LOG      = 5'd7;
    localparam t_op OP_LN_SUB   = 5'd8;
    localparam t_op OP_LN_MUL   = 5'd9;
    localparam t_op OP_SQ_INIT  = 5'd10;
    localparam t_op OP_SQ       = 5'd11;
    localparam t_op OP_ANG_PREP = 5'd12;
    localparam t_op OP_ANG_MUL  = 5'd13;
    localparam t_op OP_X_SET    = 5'd14;
    localparam t_op OP_X2_MUL   = 5'd15;
    localparam t_op OP_X2_SET   = 5'd16;
    localparam t_op OP_T_MUL    = 5'd17;
    localparam t_op OP_T_REC    = 5'd18;
    localparam t_op OP_T_COR    = 5'd19;
    localparam t_op OP_SIN_MUL  = 5'd20;
    localparam t_op OP_SIN_SET  = 5'd21;
    localparam t_op OP_Z0_MUL   = 5'd22;
    localparam t_op OP_Z0_SET   = 5'd23;
    localparam t_op OP_Z1_MUL   = 5'd24;
    localparam t_op OP_Z1_SET   = 5'd25;

    // last step index of each iterative phase
    localparam logic [4:0] LOG_LAST = 5'd27;
    localparam logic [4:0] SQ_LAST  = 5'd31;
    localparam logic [4:0] SIN_LAST = 5'd3;
    localparam logic [4:0] COS_LAST = 5'd8;

    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_MEAN   = 2'd1;
    localparam logic [1:0] CFG_SPREAD = 2'd2;

    typedef struct packed {
        t_op        op;
        logic [4:0] idx;
    } t_cmd;

    typedef struct packed {
        logic pending;
        logic reject;
        logic out_free;
    } t_status;

endpackage

// ----- hw/rtl/bmns_datapath.sv -----
module bmns_datapath
    import bmns_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    input  logic [UW-1:0]        i_in_a,
    input  logic [UW-1:0]        i_in_b,
    input  logic signed [31:0]   i_mean,
    input  logic [30:0]          i_spread,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [DW-1:0]        o_out_data
);

    function automatic logic [31:0] log2_q28(input logic [31:0] x);
        logic [63:0] m;
        logic [31:0] res;
        int          e;
        e = 0;
        for (int k = 0; k < 32; k++) begin
            if (x[k]) e = k;
        end
        m = 64'(x) << (30 - e);
        res = 32'(e) << 28;
        for (int i = 1; i <= 28; i++) begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30)) begin
                m = m >> 1;
                res[28-i] = 1'b1;
            end
        end
        return res;
    endfunction

    function automatic logic [31:0] sat36(input logic signed [35:0] v);
        if (v > 36'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -36'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic logic [6:0] div_of(input logic [4:0] j);
        case (j)
            5'd0:    return 7'd72;
            5'd1:    return 7'd42;
            5'd2:    return 7'd20;
            5'd3:    return 7'd6;
            5'd4:    return 7'd90;
            5'd5:    return 7'd56;
            5'd6:    return 7'd30;
            5'd7:    return 7'd12;
            default: return 7'd2;
        endcase
    endfunction

    function automatic logic [31:0] recip_of(input logic [4:0] j);
        case (j)
            5'd0:    return 32'((64'd1 << 32) / 72);
            5'd1:    return 32'((64'd1 << 32) / 42);
            5'd2:    return 32'((64'd1 << 32) / 20);
            5'd3:    return 32'((64'd1 << 32) / 6);
            5'd4:    return 32'((64'd1 << 32) / 90);
            5'd5:    return 32'((64'd1 << 32) / 56);
            5'd6:    return 32'((64'd1 << 32) / 30);
            5'd7:    return 32'((64'd1 << 32) / 12);
            default: return 32'((64'd1 << 32) / 2);
        endcase
    endfunction

    localparam logic [31:0] LOG2_UMAX = log2_q28(32'(UNIFORM_MAX));
    localparam logic [31:0] TWO_LN2   = 32'd372130559;
    localparam logic [31:0] TWO_PI    = 32'd1686629713;
    localparam logic [28:0] ONE_Q28   = 29'h1000_0000;
    localparam logic [63:0] PH_K      = (64'd1 << 32) / UNIFORM_MAX;
    localparam logic [63:0] PH_R      = (64'd1 << 32) % UNIFORM_MAX;
    localparam int          REJ_MAX   = UNIFORM_MAX / 10000000;

    logic [UW-1:0]        r_a;
    logic [31:0]          r_ph;
    logic [30:0]          r_m;
    logic [31:0]          r_la;
    logic [63:0]          r_n;
    logic [63:0]          r_res;
    logic [30:0]          r_w;
    logic [27:0]          r_x;
    logic [27:0]          r_x2;
    logic [28:0]          r_tt;
    logic [28:0]          r_s;
    logic [27:0]          r_p;
    logic [63:0]          r_prod;
    logic signed [31:0]   r_z;
    logic signed [31:0]   r_stored;
    logic                 r_pending;
    logic                 r_out_valid;
    logic [DW-1:0]        r_out_data;

    logic [31:0]          w_ma;
    logic [31:0]          w_mb;
    logic [63:0]          w_mul;
    logic                 w_mul_en;
    logic [UW-1:0]        w_a_sat;
    logic [3:0]           w_e;
    logic [63:0]          w_extra;
    logic [31:0]          w_ph;
    logic [31:0]          w_mm;
    logic [63:0]          w_bit;
    logic [63:0]          w_rb;
    logic [27:0]          w_q;
    logic [34:0]          w_rem;
    logic [27:0]          w_q1;
    logic [28:0]          w_cs;
    logic [28:0]          w_sn;
    logic [28:0]          w_cmag;
    logic [28:0]          w_smag;
    logic                 w_cneg;
    logic                 w_sneg;
    logic [35:0]          w_zv;
    logic [31:0]          w_zpos;
    logic [31:0]          w_zneg;
    logic [31:0]          w_zmag;
    logic [63:0]          w_rnd;
    logic signed [35:0]   w_sig_m;
    logic signed [35:0]   w_sig_sum;
    logic signed [35:0]   w_uni_sum;

    // Saturate the first word, find its leading one, form the phase in turns.
    always_comb begin
        w_a_sat = (i_in_a > UW'(UNIFORM_MAX)) ? UW'(UNIFORM_MAX) : i_in_a;
        w_e = '0;
        for (int k = 0; k < UW; k++) begin
            if (w_a_sat[k]) w_e = 4'(k);
        end
        w_extra = '0;
        for (int k = 1; k <= int'(PH_R); k++) begin
            if (64'(i_in_b) * PH_R >= 64'(k) * 64'(UNIFORM_MAX)) w_extra = w_extra + 64'd1;
        end
        w_ph = 32'(64'(i_in_b) * PH_K + w_extra);
    end

    // Octant fold and quadrant rotation of the sin/cos magnitudes
    always_comb begin
        if (r_ph[29]) begin
            w_cs = r_s;
            w_sn = r_tt;
        end else begin
            w_cs = r_tt;
            w_sn = r_s;
        end
        w_cmag = r_ph[30] ? w_sn : w_cs;
        w_smag = r_ph[30] ? w_cs : w_sn;
        w_cneg = r_ph[31] ^ r_ph[30];
        w_sneg = r_ph[31];
    end

    // shared multiplier operand select
    always_comb begin
        w_ma     = '0;
        w_mb     = '0;
        w_mul_en = 1'b1;
        case (i_cmd.op)
            OP_LOG: begin
                w_ma = {1'b0, r_m};
                w_mb = {1'b0, r_m};
            end
            OP_LN_MUL: begin
                w_ma = r_n[31:0];
                w_mb = TWO_LN2;
            end
            OP_ANG_MUL: begin
                w_ma = {1'b0, r_w};
                w_mb = TWO_PI;
            end
            OP_X2_MUL: begin
                w_ma = {4'b0, r_x};
                w_mb = {4'b0, r_x};
            end
            OP_T_MUL: begin
                w_ma = {4'b0, r_x2};
                w_mb = {3'b0, r_tt};
            end
            OP_T_REC: begin
                w_ma = {4'b0, r_prod[55:28]};
                w_mb = recip_of(i_cmd.idx);
            end
            OP_SIN_MUL: begin
                w_ma = {4'b0, r_x};
                w_mb = {3'b0, r_tt};
            end
            OP_Z0_MUL: begin
                w_ma = r_res[31:0];
                w_mb = {3'b0, w_cmag};
            end
            OP_Z1_MUL: begin
                w_ma = r_res[31:0];
                w_mb = {3'b0, w_smag};
            end
            OP_SIG_MUL: begin
                w_ma = w_zmag;
                w_mb = {1'b0, i_spread};
            end
            OP_UNI_MUL: begin
                w_ma = {1'b0, i_spread};
                w_mb = 32'(r_a);
            end
            default: w_mul_en = 1'b0;
        endcase
    end

    assign w_mul = 64'(w_ma) * 64'(w_mb);

    always_comb begin
        w_mm  = w_mul[61:30];
        w_bit = 64'd1 << (7'd62 - 7'({i_cmd.idx, 1'b0}));
        w_rb  = r_res + w_bit;
        w_q   = r_prod[59:32];
        w_rem = 35'(r_p) - 35'(w_q) * 35'(div_of(i_cmd.idx));
        w_q1  = (w_rem >= 35'(div_of(i_cmd.idx))) ? w_q + 28'd1 : w_q;
        w_zv  = r_prod[63:28];
        w_zpos = (w_zv > 36'h07FFF_FFFF) ? 32'h7FFF_FFFF : w_zv[31:0];
        w_zneg = (w_zv > 36'h080000000) ? 32'h8000_0000 : 32'(-w_zv);
        w_zmag = r_z[31] ? 32'(-r_z) : 32'(r_z);
        w_rnd  = r_prod + (64'd1 << 27);
        w_sig_m   = $signed({1'b0, w_rnd[62:28]});
        w_sig_sum = (r_z[31] ? -w_sig_m : w_sig_m) + 36'(i_mean);
        w_uni_sum = $signed({3'b0, r_prod[UW+31:UW-1]}) + 36'(i_mean)
                    - $signed({5'b0, i_spread});
    end

    always_ff @(posedge i_clk) begin
        if (w_mul_en) r_prod <= w_mul;
        case (i_cmd.op)
            OP_LOAD: begin
                r_a  <= w_a_sat;
                r_ph <= w_ph;
                r_m  <= 31'(w_a_sat) << (5'd30 - 5'(w_e));
                r_la <= 32'(w_e) << 28;
            end
            OP_LOG: begin
                if (w_mm[31]) begin
                    r_m <= w_mm[31:1];
                    r_la[5'd27 - i_cmd.idx] <= 1'b1;
                end else begin
                    r_m <= w_mm[30:0];
                end
            end
            OP_LN_SUB:   r_n <= (LOG2_UMAX > r_la) ? 64'(LOG2_UMAX - r_la) : 64'd0;
            OP_SQ_INIT: begin
                r_n   <= {r_prod[63:28], 28'b0};
                r_res <= '0;
            end
            OP_SQ: begin
                if (r_n >= w_rb) begin
                    r_n   <= r_n - w_rb;
                    r_res <= (r_res >> 1) + w_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
            end
            OP_ANG_PREP: r_w <= r_ph[29] ? 31'((31'd1 << 30) - 31'(r_ph[29:0]))
                                         : 31'(r_ph[29:0]);
            OP_X_SET:    r_x <= r_prod[59:32];
            OP_X2_SET: begin
                r_x2 <= r_prod[55:28];
                r_tt <= ONE_Q28;
            end
            OP_T_REC:    r_p  <= r_prod[55:28];
            OP_T_COR:    r_tt <= ONE_Q28 - 29'(w_q1);
            OP_SIN_SET: begin
                r_s  <= r_prod[56:28];
                r_tt <= ONE_Q28;
            end
            OP_Z0_SET:   r_z <= w_cneg ? w_zneg : w_zpos;
            OP_PEND:     r_z <= r_stored;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= 1'b0;
            r_stored    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == OP_Z1_SET) begin
                r_stored  <= w_sneg ? w_zneg : w_zpos;
                r_pending <= 1'b1;
            end else if (i_cmd.op == OP_PEND) begin
                r_pending <= 1'b0;
            end
            if (i_cmd.op == OP_SIG_FIN || i_cmd.op == OP_UNI_FIN) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_SIG_FIN) r_out_data <= sat36(w_sig_sum);
        else if (i_cmd.op == OP_UNI_FIN) r_out_data <= sat36(w_uni_sum);
    end

    assign o_status.pending  = r_pending;
    assign o_status.reject   = (32'(r_a) <= 32'(REJ_MAX));
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out_data;

endmodule

// ----- hw/rtl/bmns_controller.sv -----
module bmns_controller
    import bmns_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_mode,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_DECIDE   = 5'd1;
    localparam logic [4:0] S_UNI_MUL  = 5'd2;
    localparam logic [4:0] S_UNI_FIN  = 5'd3;
    localparam logic [4:0] S_PEND     = 5'd4;
    localparam logic [4:0] S_SIG_MUL  = 5'd5;
    localparam logic [4:0] S_SIG_FIN  = 5'd6;
    localparam logic [4:0] S_LOG      = 5'd7;
    localparam logic [4:0] S_LN_SUB   = 5'd8;
    localparam logic [4:0] S_LN_MUL   = 5'd9;
    localparam logic [4:0] S_SQ_INIT  = 5'd10;
    localparam logic [4:0] S_SQ       = 5'd11;
    localparam logic [4:0] S_ANG_PREP = 5'd12;
    localparam logic [4:0] S_ANG_MUL  = 5'd13;
    localparam logic [4:0] S_X_SET    = 5'd14;
    localparam logic [4:0] S_X2_MUL   = 5'd15;
    localparam logic [4:0] S_X2_SET   = 5'd16;
    localparam logic [4:0] S_T_MUL    = 5'd17;
    localparam logic [4:0] S_T_REC    = 5'd18;
    localparam logic [4:0] S_T_COR    = 5'd19;
    localparam logic [4:0] S_SIN_MUL  = 5'd20;
    localparam logic [4:0] S_SIN_SET  = 5'd21;
    localparam logic [4:0] S_Z0_MUL   = 5'd22;
    localparam logic [4:0] S_Z0_SET   = 5'd23;
    localparam logic [4:0] S_Z1_MUL   = 5'd24;
    localparam logic [4:0] S_Z1_SET   = 5'd25;

    logic [4:0] r_state;
    logic [4:0] n_state;
    logic [4:0] r_cnt;
    logic [4:0] n_cnt;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        o_cmd.op  = OP_NOP;
        o_cmd.idx = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_mode) begin
                    n_state = S_UNI_MUL;
                end else if (i_status.pending) begin
                    n_state = S_PEND;
                end else if (i_status.reject) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_LOG;
                    n_cnt   = '0;
                end
            end
            S_UNI_MUL: begin
                o_cmd.op = OP_UNI_MUL;
                n_state  = S_UNI_FIN;
            end
            S_UNI_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_UNI_FIN;
                    n_state  = S_IDLE;
                end
            end
            S_PEND: begin
                o_cmd.op = OP_PEND;
                n_state  = S_SIG_MUL;
            end
            S_SIG_MUL: begin
                o_cmd.op = OP_SIG_MUL;
                n_state  = S_SIG_FIN;
            end
            S_SIG_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_SIG_FIN;
                    n_state  = S_IDLE;
                end
            end
            S_LOG: begin
                o_cmd.op = OP_LOG;
                n_cnt    = r_cnt + 5'd1;
                if (r_cnt == LOG_LAST) n_state = S_LN_SUB;
            end
            S_LN_SUB: begin
                o_cmd.op = OP_LN_SUB;
                n_state  = S_LN_MUL;
            end
            S_LN_MUL: begin
                o_cmd.op = OP_LN_MUL;
                n_state  = S_SQ_INIT;
            end
            S_SQ_INIT: begin
                o_cmd.op = OP_SQ_INIT;
                n_cnt    = '0;
                n_state  = S_SQ;
            end
            S_SQ: begin
                o_cmd.op = OP_SQ;
                n_cnt    = r_cnt + 5'd1;
                if (r_cnt == SQ_LAST) n_state = S_ANG_PREP;
            end
            S_ANG_PREP: begin
                o_cmd.op = OP_ANG_PREP;
                n_state  = S_ANG_MUL;
            end
            S_ANG_MUL: begin
                o_cmd.op = OP_ANG_MUL;
                n_state  = S_X_SET;
            end
            S_X_SET: begin
                o_cmd.op = OP_X_SET;
                n_state  = S_X2_MUL;
            end
            S_X2_MUL: begin
                o_cmd.op = OP_X2_MUL;
                n_state  = S_X2_SET;
            end
            S_X2_SET: begin
                o_cmd.op = OP_X2_SET;
                n_cnt    = '0;
                n_state  = S_T_MUL;
            end
            S_T_MUL: begin
                o_cmd.op = OP_T_MUL;
                n_state  = S_T_REC;
            end
            S_T_REC: begin
                o_cmd.op = OP_T_REC;
                n_state  = S_T_COR;
            end
            S_T_COR: begin
                o_cmd.op = OP_T_COR;
                n_cnt    = r_cnt + 5'd1;
                if (r_cnt == SIN_LAST) n_state = S_SIN_MUL;
                else if (r_cnt == COS_LAST) n_state = S_Z0_MUL;
                else n_state = S_T_MUL;
            end
            S_SIN_MUL: begin
                o_cmd.op = OP_SIN_MUL;
                n_state  = S_SIN_SET;
            end
            S_SIN_SET: begin
                o_cmd.op = OP_SIN_SET;
                n_state  = S_T_MUL;
            end
            S_Z0_MUL: begin
                o_cmd.op = OP_Z0_MUL;
                n_state  = S_Z0_SET;
            end
            S_Z0_SET: begin
                o_cmd.op = OP_Z0_SET;
                n_state  = S_Z1_MUL;
            end
            S_Z1_MUL: begin
                o_cmd.op = OP_Z1_MUL;
                n_state  = S_Z1_SET;
            end
            S_Z1_SET: begin
                o_cmd.op = OP_Z1_SET;
                n_state  = S_SIG_MUL;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ----- hw/rtl/box_muller_noise_sampler.sv -----
// Uniform mode: an accepted item passes the decide, multiply and finish states;
// a stored second sample passes the decide, pend, multiply and finish states.
// A fresh Box-Muller pair runs the 28-step log2 squaring loop, the 32-step square
// root and the 9-term sin/cos series, all on one multiplier, and stores the second
// sample. A rejected item returns the block to idle from the decide state.
// Reset (synchronous, active low) clears controller, pair flag and output valid; mode 0.
module box_muller_noise_sampler
    import bmns_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [31:0]   s_axis_tdata,   // [14:0] uniform_a, [29:15] uniform_b, zero pad
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [31:0]   m_axis_tdata,   // [31:0] noise_sample
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_addr,
    input  logic [31:0]   i_cfg_wdata
);

    // One item is in flight at a time; a stalled result holds the block in its
    // final step until the output is taken. Mean 0 and spread 1.0 after reset.

    logic               r_mode;
    logic signed [31:0] r_mean;
    logic [30:0]        r_spread;
    t_cmd               w_cmd;
    t_status            w_status;

    // configuration registers; writes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b0;
            r_mean   <= '0;
            r_spread <= 31'd65536;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_MODE:   r_mode   <= i_cfg_wdata[0];
                CFG_MEAN:   r_mean   <= $signed(i_cfg_wdata);
                CFG_SPREAD: r_spread <= i_cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    // sequencing: accept, pick the path, step the iterative units
    bmns_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_mode     (r_mode),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // shared multiplier, log/sqrt/series registers, pair store, output register
    bmns_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_a      (s_axis_tdata[UW-1:0]),
        .i_in_b      (s_axis_tdata[2*UW-1:UW]),
        .i_mean      (r_mean),
        .i_spread    (r_spread),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule

// ----- hw/rtl/bmns_checker.sv -----
module bmns_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // a waiting result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

    // one item in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second item accepted while busy");

    // no result can appear in the cycle after an accept
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !$rose(m_axis_tvalid))
        else $error("result too early");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind box_muller_noise_sampler bmns_checker u_bmns_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
